/* rtl/hcs_pkg.sv */
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared constants for the harmonic comb scorer: defaults, item kinds,
// register indexes and field widths.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int SPEC_LEN_DEF  = 512;
  localparam int MAX_PEAKS_DEF = 256;
  localparam int MAX_CANDS_DEF = 8;
  localparam int MAX_HARM_DEF  = 16;

  localparam logic [1:0] KIND_BIN    = 2'd0;
  localparam logic [1:0] KIND_PEAK   = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] REG_CAND_COUNT   = 2'd0;
  localparam logic [1:0] REG_MAX_PARTIALS = 2'd1;
  localparam logic [1:0] REG_SPEC_LENGTH  = 2'd2;

  localparam int POS_W    = 18;
  localparam int MAG_W    = 16;
  localparam int ENERGY_W = 20;
  localparam int CFG_W    = 10;
  localparam int SQ_W     = 24;
  localparam int ROOT4_W  = 12;

  localparam logic [3:0] CAND_COUNT_RST   = 4'd5;
  localparam logic [4:0] MAX_PARTIALS_RST = 5'd5;
  localparam logic [9:0] SPEC_LENGTH_RST  = 10'd512;

endpackage

/* rtl/harmonic_comb_scorer.sv */
// ----------------------------------------------------------------------------
// harmonic_comb_scorer
// Subharmonic comb pitch scorer over a stored spectrum and peak list.
// ----------------------------------------------------------------------------
// Bin and peak write items can come back to back. A run item holds busy until
// its last result; how long is set by the peak memory scan per harmonic and
// the bit-serial fourth-root unit. Each result is one strobe; the receiver
// cannot stall. Reset clears control and registers; stores stay undefined.
module harmonic_comb_scorer #(
  parameter int SPEC_LEN      = hcs_pkg::SPEC_LEN_DEF,
  parameter int MAX_PEAKS     = hcs_pkg::MAX_PEAKS_DEF,
  parameter int MAX_CANDS     = hcs_pkg::MAX_CANDS_DEF,
  parameter int MAX_HARMONICS = hcs_pkg::MAX_HARM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [8:0]                  slot,
  input  logic [hcs_pkg::MAG_W-1:0]   magnitude,
  input  logic signed [hcs_pkg::POS_W-1:0] peak_position,
  input  logic [8:0]                  peak_count,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [hcs_pkg::CFG_W-1:0]   cfg_data,
  output logic                        result_strobe,
  output logic [2:0]                  cand_index,
  output logic signed [hcs_pkg::POS_W-1:0] cand_bin,
  output logic [hcs_pkg::ENERGY_W-1:0] comb_energy,
  output logic [4:0]                  matched_partials,
  output logic [4:0]                  comb_length,
  output logic [2:0]                  best_candidate,
  output logic                        last
);

  localparam int SA  = $clog2(SPEC_LEN);
  localparam int PA  = $clog2(MAX_PEAKS);
  localparam int PW  = $clog2(MAX_PEAKS + 1);
  localparam int CW  = $clog2(MAX_CANDS + 1);
  localparam int DVW = CW + 1;
  localparam int KW  = $clog2(MAX_HARMONICS + 1);
  localparam int SLW = $clog2(SPEC_LEN + 1);
  // harmonic position width: room for the limit plus one bin step
  localparam int HW  = ((SLW + 8) > 17 ? (SLW + 8) : 17) + 1;
  localparam int DW  = HW + 1;
  localparam int PSW = hcs_pkg::POS_W;
  localparam int EW  = hcs_pkg::ENERGY_W;
  localparam int QW  = hcs_pkg::SQ_W;
  localparam int RW  = hcs_pkg::ROOT4_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RSCAN  = 4'd1;
  localparam logic [3:0] S_ROOT_RD = 4'd2;
  localparam logic [3:0] S_ROOT_TK = 4'd3;
  localparam logic [3:0] S_CAND   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_HCHECK = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_MATCH  = 4'd8;
  localparam logic [3:0] S_SPEC   = 4'd9;
  localparam logic [3:0] S_ROOT4  = 4'd10;
  localparam logic [3:0] S_NEXTH  = 4'd11;

  // stores
  logic [hcs_pkg::MAG_W-1:0] spec_mem [SPEC_LEN];
  logic [PSW-1:0]            pos_mem  [MAX_PEAKS];
  logic [hcs_pkg::MAG_W-1:0] mag_mem  [MAX_PEAKS];
  logic [hcs_pkg::MAG_W-1:0] spec_q, mag_q;
  logic [PSW-1:0]            pos_q;
  logic [SA-1:0]             spec_raddr;
  logic [PA-1:0]             pos_raddr;

  // configuration
  logic [3:0]  cand_count;
  logic [4:0]  max_partials;
  logic [9:0]  spectrum_length;

  // run control
  logic [3:0]  state;
  logic [PW-1:0] npeaks, issue;
  logic        dv;
  logic [PA-1:0] didx, top_pos;
  logic [hcs_pkg::MAG_W-1:0] top_mag;
  logic [CW-1:0] ncand, l;
  logic [KW-1:0] npart, k, matched;
  logic [SLW-1:0] slen;
  logic signed [PSW-1:0] root, bin, near;
  logic [PSW-1:0] quo;
  logic [DVW-1:0] rem;
  logic [4:0]  step;
  logic [HW-1:0] h;
  logic [DW-1:0] best_d;
  logic [EW-1:0] energy, best_energy;
  logic [CW-1:0] best_index;
  logic [hcs_pkg::MAG_W-1:0] root4_m;
  logic [QW-1:0] sq_s;
  logic [RW-1:0] r4;
  logic        phase_b;

  wire accept = start && !busy;
  assign busy = (state != S_IDLE);

  logic [31:0] slot32;
  assign slot32 = 32'(slot);

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (accept && kind == hcs_pkg::KIND_BIN && slot32 < 32'(SPEC_LEN)) begin
      spec_mem[slot32[SA-1:0]] <= magnitude;
    end
    if (accept && kind == hcs_pkg::KIND_PEAK && slot32 < 32'(MAX_PEAKS)) begin
      pos_mem[slot32[PA-1:0]] <= peak_position;
      mag_mem[slot32[PA-1:0]] <= magnitude;
    end
    spec_q <= spec_mem[spec_raddr];
    pos_q  <= pos_mem[pos_raddr];
    mag_q  <= mag_mem[issue[PA-1:0]];
  end

  // run-start clamps
  logic [31:0] pc32, cc32, mp32, sl32;
  logic [PW-1:0]  npeaks_next;
  logic [CW-1:0]  ncand_next;
  logic [KW-1:0]  npart_next;
  logic [SLW-1:0] slen_next;
  always_comb begin
    pc32 = 32'(peak_count);
    cc32 = 32'(cand_count);
    mp32 = 32'(max_partials);
    sl32 = 32'(spectrum_length);
    npeaks_next = (pc32 > 32'(MAX_PEAKS)) ? PW'(MAX_PEAKS) : PW'(pc32);
    if (cc32 == 32'd0)                 ncand_next = CW'(1);
    else if (cc32 > 32'(MAX_CANDS))    ncand_next = CW'(MAX_CANDS);
    else                               ncand_next = CW'(cc32);
    npart_next = (mp32 > 32'(MAX_HARMONICS)) ? KW'(MAX_HARMONICS) : KW'(mp32);
    slen_next  = (sl32 > 32'(SPEC_LEN)) ? SLW'(SPEC_LEN) : SLW'(sl32);
  end

  // divider step: |root| / (l+1), one quotient bit a cycle
  logic [DVW-1:0] divisor;
  logic [DVW:0]   rem_sh;
  logic           div_ge;
  assign divisor = DVW'(l) + DVW'(1);
  assign rem_sh  = {rem, quo[PSW-1]};
  assign div_ge  = rem_sh >= (DVW+1)'(divisor);

  // nearest-peak distance
  logic signed [HW+1:0] diff;
  logic [DW-1:0]        adiff;
  always_comb begin
    diff  = $signed({2'b00, h}) - (HW+2)'($signed(pos_q));
    adiff = diff[HW+1] ? DW'(-diff) : DW'(diff);
  end

  // match test and rounded bin
  logic [DW+4:0]   mul17;
  logic            is_match;
  logic signed [PSW:0] rnd;
  logic [31:0]     idx32;
  logic            idx_ok;
  always_comb begin
    mul17    = (DW+5)'({best_d, 4'b0000}) + (DW+5)'(best_d);
    is_match = mul17 < (DW+5)'(h);
    rnd      = $signed({near[PSW-1], near}) + (PSW+1)'(128);
    idx32    = 32'(rnd[PSW-1:8]);
    idx_ok   = !rnd[PSW] && (idx32 < 32'(slen));
  end

  // fourth root: isqrt(isqrt(m << 32)), one result bit a cycle
  logic [QW-1:0]   bitq, trial;
  logic [2*QW-1:0] prod, target;
  logic            fits;
  logic [RW-1:0]   r4_final;
  always_comb begin
    bitq   = QW'(1) << step;
    trial  = phase_b ? ({{(QW-RW){1'b0}}, r4} | bitq) : (sq_s | bitq);
    prod   = trial * trial;
    target = phase_b ? (2*QW)'(sq_s) : {root4_m, 32'h0};
    fits   = prod <= target;
    r4_final = fits ? trial[RW-1:0] : r4;
  end

  // harmonic limit and candidate wrap-up
  logic          bin_pos, h_ok, is_last, upd;
  always_comb begin
    bin_pos = !bin[PSW-1] && (bin != '0);
    h_ok    = bin_pos && (k < npart) && (h <= HW'({slen, 8'h00}));
    is_last = (l == ncand - CW'(1));
    upd     = best_energy < energy;
  end

  // memory read addresses
  always_comb begin
    pos_raddr  = (state == S_ROOT_RD) ? top_pos : issue[PA-1:0];
    spec_raddr = idx32[SA-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cand_count      <= hcs_pkg::CAND_COUNT_RST;
      max_partials    <= hcs_pkg::MAX_PARTIALS_RST;
      spectrum_length <= hcs_pkg::SPEC_LENGTH_RST;
      best_energy     <= '0;
      best_index      <= '0;
      result_strobe   <= 1'b0;
      dv              <= 1'b0;
      k               <= '0;
      matched         <= '0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          hcs_pkg::REG_CAND_COUNT:   cand_count      <= cfg_data[3:0];
          hcs_pkg::REG_MAX_PARTIALS: max_partials    <= cfg_data[4:0];
          hcs_pkg::REG_SPEC_LENGTH:  spectrum_length <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept && kind == hcs_pkg::KIND_RUN) begin
            npeaks      <= npeaks_next;
            ncand       <= ncand_next;
            npart       <= npart_next;
            slen        <= slen_next;
            best_energy <= '0;
            best_index  <= '0;
            l           <= '0;
            issue       <= '0;
            dv          <= 1'b0;
            top_mag     <= '0;
            top_pos     <= '0;
            if (npeaks_next == '0) begin
              root  <= '0;
              state <= S_CAND;
            end else begin
              state <= S_RSCAN;
            end
          end
        end
        S_RSCAN: begin
          if (issue < npeaks) begin
            issue <= issue + PW'(1);
            didx  <= issue[PA-1:0];
            dv    <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          // last one wins a tie
          if (dv && mag_q >= top_mag) begin
            top_mag <= mag_q;
            top_pos <= didx;
          end
          if (issue == npeaks && !dv) state <= S_ROOT_RD;
        end
        S_ROOT_RD: state <= S_ROOT_TK;
        S_ROOT_TK: begin
          root  <= $signed(pos_q);
          state <= S_CAND;
        end
        S_CAND: begin
          rem   <= '0;
          quo   <= root[PSW-1] ? PSW'(-root) : PSW'(root);
          step  <= 5'(PSW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= div_ge ? DVW'(rem_sh - (DVW+1)'(divisor)) : DVW'(rem_sh);
          quo <= {quo[PSW-2:0], div_ge};
          if (step == 5'd0) begin
            // truncate toward zero
            bin     <= root[PSW-1] ? -$signed({quo[PSW-2:0], div_ge})
                                   : $signed({quo[PSW-2:0], div_ge});
            h       <= HW'({quo[PSW-2:0], div_ge});
            k       <= '0;
            matched <= '0;
            energy  <= '0;
            state   <= S_HCHECK;
          end else begin
            step <= step - 5'd1;
          end
        end
        S_HCHECK: begin
          if (h_ok) begin
            issue  <= '0;
            dv     <= 1'b0;
            best_d <= '1;
            near   <= '0;
            state  <= S_SCAN;
          end else begin
            result_strobe    <= 1'b1;
            cand_index       <= 3'(l);
            cand_bin         <= bin;
            comb_energy      <= energy;
            matched_partials <= 5'(matched);
            comb_length      <= 5'(k);
            last             <= is_last;
            if (upd) begin
              best_energy <= energy;
              best_index  <= l;
            end
            best_candidate <= is_last ? 3'(upd ? l : best_index) : 3'd0;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              l     <= l + CW'(1);
              state <= S_CAND;
            end
          end
        end
        S_SCAN: begin
          if (issue < npeaks) begin
            issue <= issue + PW'(1);
            dv    <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv && adiff <= best_d) begin
            best_d <= adiff;
            near   <= $signed(pos_q);
          end
          if (issue == npeaks && !dv) state <= S_MATCH;
        end
        S_MATCH: begin
          if (is_match) begin
            matched <= matched + KW'(1);
            state   <= idx_ok ? S_SPEC : S_NEXTH;
          end else begin
            state <= S_NEXTH;
          end
        end
        S_SPEC: begin
          root4_m <= spec_q;
          sq_s    <= '0;
          r4      <= '0;
          phase_b <= 1'b0;
          step    <= 5'(QW - 1);
          state   <= S_ROOT4;
        end
        S_ROOT4: begin
          if (!phase_b) begin
            if (fits) sq_s <= trial;
            if (step == 5'd0) begin
              phase_b <= 1'b1;
              step    <= 5'(RW - 1);
            end else begin
              step <= step - 5'd1;
            end
          end else begin
            r4 <= r4_final;
            if (step == 5'd0) begin
              energy <= energy + EW'(r4_final);
              state  <= S_NEXTH;
            end else begin
              step <= step - 5'd1;
            end
          end
        end
        S_NEXTH: begin
          k     <= k + KW'(1);
          h     <= h + HW'(bin);
          state <= S_HCHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the final result of a run leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last) |-> (state == S_IDLE))
    else $error("last result while still running");

  // a result only follows the end of a comb
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(state) == S_HCHECK))
    else $error("result strobe without a finished comb");

  // matched harmonics never outnumber those tried
  a_match_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_HCHECK) |-> (matched <= k))
    else $error("matched count above comb length");

  // a run only returns to idle from the wrap-up of its last comb
  a_no_run_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (state != S_IDLE) || $past(state == S_HCHECK))
    else $error("run left without finishing its last comb");

endmodule
